>>> sv/min_heap_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// min_heap_priority_queue_macros.svh
// Assertion macros used by the priority queue checker.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Clocked property, disabled during reset; expects clk and rst in scope
`define MHPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define MHPQ_IMPLY(label, ante, cons, msg) \
  `MHPQ_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> sv/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and constants for the min priority queue and its sorted cell row.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic        [COUNT_WIDTH-1:0] count_t;
  typedef logic        [1:0]             status_t;

  // Opcodes of the input word
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Status codes of the result word
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    value_t    key;
  } cell_ctrl_t;

endpackage

>>> sv/mhpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted row. Holds a value and, on an insert, keeps it,
// takes the key or takes the left neighbour's value; on an extract it takes
// the right neighbour's value.
// ----------------------------------------------------------------------------
module mhpq_cell (
  input  logic                clk,
  input  mhpq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  logic                left_ge,
  input  mhpq_pkg::value_t    left_value,
  input  mhpq_pkg::value_t    right_value,
  output mhpq_pkg::value_t    value,
  output logic                ge
);
  import mhpq_pkg::*;

  value_t value_next;

  // key sits at or beyond this slot
  assign ge = occ && (ctrl.key >= value);

  // next slot content
  always_comb begin
    value_next = value;
    case (ctrl.cmd)
      CMD_INSERT: begin
        if (ge) begin
          value_next = value;
        end else if (left_ge) begin
          value_next = ctrl.key;
        end else begin
          value_next = left_value;
        end
      end
      CMD_SHIFT: value_next = right_value;
      default:   value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> sv/min_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Min priority queue of signed values held as a sorted row of cells, with
// a running maximum and a registered result word per input word.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | in_valid/in_ready  | opcode, value
//  output  | out_valid/out_ready| status, extracted, min_value, max_value,
//          |                    | entry_count
//
//  All cells update in parallel in the cycle an input word is accepted and
//  the result is registered for the next cycle.
//  A new word is taken while the result register is empty or being drained.
//  A stalled output holds the result and stops further input.
//  Reset clears the entry count, running maximum and result valid; cell
//  contents are left as they are and only occupied slots are ever read.
// ----------------------------------------------------------------------------
module min_heap_priority_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 opcode,
  input  mhpq_pkg::value_t     value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mhpq_pkg::status_t    status,
  output mhpq_pkg::value_t     extracted,
  output mhpq_pkg::value_t     min_value,
  output mhpq_pkg::value_t     max_value,
  output mhpq_pkg::count_t     entry_count
);
  import mhpq_pkg::*;

  count_t     count;
  count_t     count_next;
  value_t     largest;
  value_t     largest_next;
  cell_ctrl_t ctrl;
  logic       accept;

  value_t     cell_value [DEPTH];
  logic       cell_ge    [DEPTH];
  logic       cell_occ   [DEPTH];

  status_t    status_next;
  value_t     extracted_next;
  value_t     min_next;
  value_t     max_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // command to the row
  always_comb begin
    ctrl.key = value;
    ctrl.cmd = CMD_HOLD;
    if (accept) begin
      if (opcode == OP_INSERT) begin
        if (count != count_t'(DEPTH)) ctrl.cmd = CMD_INSERT;
      end else begin
        if (count != '0) ctrl.cmd = CMD_SHIFT;
      end
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_occ[i] = (count > count_t'(i));
    if (i == 0) begin : g_first
      mhpq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (cell_occ[i]),
        .left_ge     (1'b1),
        .left_value  (value),
        .right_value (cell_value[i+1]),
        .value       (cell_value[i]),
        .ge          (cell_ge[i])
      );
    end else if (i == DEPTH - 1) begin : g_last
      mhpq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (cell_occ[i]),
        .left_ge     (cell_ge[i-1]),
        .left_value  (cell_value[i-1]),
        .right_value (cell_value[i]),
        .value       (cell_value[i]),
        .ge          (cell_ge[i])
      );
    end else begin : g_mid
      mhpq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (cell_occ[i]),
        .left_ge     (cell_ge[i-1]),
        .left_value  (cell_value[i-1]),
        .right_value (cell_value[i+1]),
        .value       (cell_value[i]),
        .ge          (cell_ge[i])
      );
    end
  end

  // result word and bookkeeping
  always_comb begin
    count_next     = count;
    largest_next   = largest;
    status_next    = ST_OK;
    extracted_next = '0;
    min_next       = '0;
    max_next       = '0;
    case (opcode)
      OP_INSERT: begin
        if (count == count_t'(DEPTH)) begin
          status_next = ST_FULL;
          min_next    = cell_value[0];
          max_next    = largest;
        end else begin
          count_next = count + count_t'(1);
          if (count == '0 || value > largest) largest_next = value;
          if (count == '0 || value < cell_value[0]) begin
            min_next = value;
          end else begin
            min_next = cell_value[0];
          end
          max_next = largest_next;
        end
      end
      OP_EXTRACT: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          extracted_next = cell_value[0];
          count_next     = count - count_t'(1);
          if (count_next == '0) begin
            largest_next = '0;
          end else begin
            min_next = cell_value[1];
            max_next = largest;
          end
        end
      end
      default: status_next = ST_OK;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      largest   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count   <= count_next;
        largest <= largest_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      extracted   <= extracted_next;
      min_value   <= min_next;
      max_value   <= max_next;
      entry_count <= count_next;
    end
  end

endmodule

>>> sv/mhpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks on the priority queue result word, bound to the top.
// ----------------------------------------------------------------------------
`include "min_heap_priority_queue_macros.svh"

module mhpq_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              opcode,
  input mhpq_pkg::value_t  value,
  input logic              out_valid,
  input logic              out_ready,
  input mhpq_pkg::status_t status,
  input mhpq_pkg::value_t  extracted,
  input mhpq_pkg::value_t  min_value,
  input mhpq_pkg::value_t  max_value,
  input mhpq_pkg::count_t  entry_count
);
  import mhpq_pkg::*;

  // stalled result word holds
  `MHPQ_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(extracted) && $stable(min_value) && $stable(max_value) && $stable(entry_count)), "result word changed while stalled")

  // empty status only with nothing held
  `MHPQ_IMPLY(a_empty_count, (out_valid && status == ST_EMPTY), (entry_count == '0 && extracted == '0), "empty status with entries or data")

  // full status only at capacity
  `MHPQ_IMPLY(a_full_count, (out_valid && status == ST_FULL), (entry_count == count_t'(DEPTH)), "full status below capacity")

  // min never above max while entries are held
  `MHPQ_IMPLY(a_min_le_max, (out_valid && entry_count != '0), (min_value <= max_value), "minimum above maximum")

  // empty queue reports zeros
  `MHPQ_IMPLY(a_empty_zero, (out_valid && entry_count == '0), (min_value == '0 && max_value == '0), "empty queue reports nonzero min or max")

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the min priority queue against a binary min-heap predictor. Every
// accepted input word is run through the predictor and each result word is
// compared field by field with the oldest prediction. Directed words cover
// the value extremes and the empty and last-entry cases. Random phases with
// varied insert/extract mixes then fill the queue to full and drain it, with
// random idling on both sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module testbench;
  import mhpq_pkg::*;

  localparam int RANDOM_WORDS = 600;
  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 300;

  typedef logic [VALUE_WIDTH-1:0] key_t;
  localparam key_t SIGN_FLIP = key_t'(1) << (VALUE_WIDTH - 1);

  localparam value_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef struct {
    status_t status;
    value_t  extracted;
    value_t  min_value;
    value_t  max_value;
    count_t  entry_count;
  } heap_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: heap predictor and queue of expected result words
  // --------------------------------------------------------------------------
  class heap_scoreboard;
    key_t         heap_keys[DEPTH];
    int           fill;
    key_t         largest_key;
    heap_result_t expected_words[$];
    int unsigned  error_count;

    function new();
      fill        = 0;
      largest_key = '0;
      error_count = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Applies one word to the heap copy and returns the predicted result
    function heap_result_t predict_heap_op(logic op, value_t val);
      heap_result_t r;
      key_t k;
      key_t t;
      int   pos;
      int   parent;
      int   lc;
      int   rc;
      int   best;
      r.status    = ST_OK;
      r.extracted = '0;
      k = key_t'(val) ^ SIGN_FLIP;
      if (op == OP_INSERT) begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (fill == 0 || k > largest_key) largest_key = k;
          heap_keys[fill] = k;
          pos = fill;
          fill++;
          // sift up
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (heap_keys[pos] < heap_keys[parent]) begin
              t = heap_keys[pos];
              heap_keys[pos] = heap_keys[parent];
              heap_keys[parent] = t;
              pos = parent;
            end else begin
              break;
            end
          end
        end
      end else begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.extracted = value_t'(heap_keys[0] ^ SIGN_FLIP);
          fill--;
          heap_keys[0] = heap_keys[fill];
          if (fill == 0) begin
            largest_key = '0;
          end else begin
            // sift down from the root
            pos = 0;
            forever begin
              lc = 2 * pos + 1;
              rc = 2 * pos + 2;
              best = pos;
              if (lc < fill && heap_keys[lc] < heap_keys[best]) best = lc;
              if (rc < fill && heap_keys[rc] < heap_keys[best]) best = rc;
              if (best == pos) break;
              t = heap_keys[pos];
              heap_keys[pos] = heap_keys[best];
              heap_keys[best] = t;
              pos = best;
            end
          end
        end
      end
      if (fill == 0) begin
        r.min_value = '0;
        r.max_value = '0;
      end else begin
        r.min_value = value_t'(heap_keys[0] ^ SIGN_FLIP);
        r.max_value = value_t'(largest_key ^ SIGN_FLIP);
      end
      r.entry_count = count_t'(fill);
      return r;
    endfunction

    function void note_word(logic op, value_t val);
      expected_words.insert(expected_words.size(), predict_heap_op(op, val));
    endfunction

    function void check_word(status_t st, value_t ext, value_t mn, value_t mx,
                             count_t cnt);
      heap_result_t e;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with none expected", $realtime);
        error_count++;
        return;
      end
      e = expected_words.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d got %0d", $realtime, e.status, st);
        error_count++;
      end
      if (ext !== e.extracted) begin
        $display("%0t: extracted expected %0d got %0d", $realtime, e.extracted, ext);
        error_count++;
      end
      if (mn !== e.min_value) begin
        $display("%0t: min_value expected %0d got %0d", $realtime, e.min_value, mn);
        error_count++;
      end
      if (mx !== e.max_value) begin
        $display("%0t: max_value expected %0d got %0d", $realtime, e.max_value, mx);
        error_count++;
      end
      if (cnt !== e.entry_count) begin
        $display("%0t: entry_count expected %0d got %0d", $realtime, e.entry_count,
                 cnt);
        error_count++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    in_valid  = 1'b0;
  logic    opcode    = OP_INSERT;
  value_t  value     = '0;
  logic    out_ready = 1'b0;
  logic    in_ready;
  logic    out_valid;
  status_t status;
  value_t  extracted;
  value_t  min_value;
  value_t  max_value;
  count_t  entry_count;

  heap_scoreboard sb = new();

  bit no_idle       = 1'b0;   // phase with no gaps on either side
  bit long_hold_req = 1'b0;   // asks the receiver for one long hold-off

  min_heap_priority_queue DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .extracted   (extracted),
    .min_value   (min_value),
    .max_value   (max_value),
    .entry_count (entry_count)
  );

  // Clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall per word, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else begin
        if (out_valid && out_ready) stall_left = no_idle ? 0 : $urandom_range(0, 7);
        if (long_hold_req) begin
          hold_left     = LONG_HOLD;
          long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word(status, extracted, min_value, max_value, entry_count);
  end

  // Watchdog on cycles with no word moving on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  // Offers one word after a random gap; valid stays up into the next word
  // when that word draws no gap.
  task automatic send_word(input logic op, input value_t val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_word(op, val);
  endtask

  // Stops offering until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Extremes, small values for duplicates, otherwise full range
  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return value_t'($urandom_range(0, 16)) - value_t'(8);
      4:       return ($urandom_range(0, 1) != 0) ? value_t'(-1) : value_t'(0);
      default: return value_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int sent;
    int phase_len;
    int insert_pct;
    int phase_no;
    int k;
    logic op;
    @(negedge rst);
    @(posedge clk);

    // Directed: empty extract, single entry in and out, extremes, duplicates
    send_word(OP_EXTRACT, value_t'(0));
    send_word(OP_INSERT,  VAL_MAX);
    send_word(OP_EXTRACT, value_t'(0));
    send_word(OP_EXTRACT, value_t'(-5));
    send_word(OP_INSERT,  VAL_MIN);
    send_word(OP_INSERT,  VAL_MAX);
    send_word(OP_INSERT,  value_t'(0));
    send_word(OP_INSERT,  value_t'(-1));
    send_word(OP_INSERT,  value_t'(1));
    send_word(OP_INSERT,  VAL_MIN);
    send_word(OP_INSERT,  value_t'(32'h5555_5555));
    send_word(OP_INSERT,  value_t'(32'hAAAA_AAAA));
    send_word(OP_INSERT,  VAL_MAX);
    for (k = 0; k < 10; k++) send_word(OP_EXTRACT, value_t'(32'hFFFF_FFFF));
    drain_results();

    // Random phases; the first one fills the queue and runs into full
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_WORDS) begin
      if (phase_no == 0) begin
        phase_len  = DEPTH + 8;
        insert_pct = 100;
      end else begin
        phase_len = $urandom_range(20, 80);
        case ($urandom_range(0, 4))
          0:       insert_pct = 90;
          1:       insert_pct = 70;
          2:       insert_pct = 50;
          3:       insert_pct = 30;
          default: insert_pct = 10;
        endcase
      end
      no_idle = (phase_no % 4 == 3);
      if (phase_no == 2) long_hold_req = 1'b1;
      for (k = 0; k < phase_len; k++) begin
        op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_EXTRACT;
        send_word(op, pick_value());
      end
      sent += phase_len;
      if (phase_no == 4) drain_results();
      phase_no++;
    end
    no_idle = 1'b0;

    // Wind down
    drain_results();
    repeat (16) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
